// ----- rtl/core/lis_pkg.sv -----
// Shared types and codes for the longest increasing subsequence block.
package lis_pkg;

	// Fixed field widths of the transaction payloads
	localparam int unsigned VAL_W    = 32;
	localparam int unsigned IDX_W    = 10;
	localparam int unsigned LEN_W    = 11;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned ACTION_W = 2;

	typedef logic [VAL_W-1:0]    val_t;
	typedef logic [IDX_W-1:0]    idx_t;
	typedef logic [LEN_W-1:0]    len_t;
	typedef logic [STATUS_W-1:0] status_t;

	// Request codes
	typedef enum logic [ACTION_W-1:0] {
		ACT_PUSH  = 2'd0,
		ACT_READ  = 2'd1,
		ACT_CLEAR = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	// Response codes
	localparam status_t ST_OK       = 2'd0;
	localparam status_t ST_FULL     = 2'd1;
	localparam status_t ST_BAD_READ = 2'd2;

endpackage

// ----- rtl/core/longest_increasing_subsequence.sv -----
// Top level: streaming longest strictly increasing subsequence tracker.
//
// Usage
//   Input channel (in_valid/in_ready) carries one request per transaction:
//   action push (store value, search the tails table), read (return element
//   index's value and predecessor) or clear (start a new sequence).
//   Output channel (out_valid/out_ready) returns exactly one response per
//   request, in order, from an output register.
//   A push is accepted, then makes one binary-search probe per search step
//   (at most floor(log2(best_length))+1 probes, 11 for 1024 elements) and a
//   write-back; reads, clears and rejected pushes have one result step. The
//   search loop is one tails-memory read per cycle; the tails memory holds
//   each tail's value next to its element index, so a probe needs one read.
//   One request is in work at a time; the next is accepted as soon as the
//   current result is loaded into the output register, even if that result
//   is still waiting for out_ready.
//   Reset clears the element count and best length/end; memory contents are
//   not cleared, since reads are bounded by the count, so there is no
//   clearing pass. If the receiver stalls, the finished request waits in its
//   last state and the memories are not updated until the output slot frees.
module longest_increasing_subsequence #(
	parameter int unsigned MAX_ITEMS = 1024
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// request channel
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [1:0]                action,
	input  logic signed [31:0]        value,
	input  logic [9:0]                index,
	// response channel
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [1:0]                status,
	output logic [10:0]               position,
	output logic [10:0]               best_length,
	output logic [9:0]                best_end,
	output logic signed [31:0]        entry_value,
	output logic [9:0]                entry_pred,
	output logic                      pred_valid
);

	localparam int unsigned IW   = $clog2(MAX_ITEMS);
	localparam int unsigned CW   = $clog2(MAX_ITEMS + 1);
	localparam int unsigned CMPW = (CW > lis_pkg::IDX_W) ? CW : lis_pkg::IDX_W;
	localparam int unsigned VW   = lis_pkg::VAL_W;
	localparam int unsigned TW   = VW + IW;
	localparam int unsigned EW   = VW + IW + 1;

	typedef logic [CW-1:0] cnt_t;
	typedef logic [IW-1:0] addr_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_WRITE,
		S_RDATA,
		S_DONE
	} state_t;

	state_t               state_q;
	lis_pkg::status_t     st_q;
	logic [VW-1:0]        val_q;
	cnt_t                 count_q;
	cnt_t                 best_len_q;
	addr_t                best_tail_q;
	cnt_t                 lo_q;
	cnt_t                 hi_q;
	cnt_t                 mid_q;
	addr_t                pred_q;
	logic                 pred_ok_q;

	logic                 out_valid_q;
	lis_pkg::status_t     status_q;
	lis_pkg::len_t        position_q;
	lis_pkg::len_t        best_length_q;
	lis_pkg::idx_t        best_end_q;
	lis_pkg::val_t        entry_value_q;
	lis_pkg::idx_t        entry_pred_q;
	logic                 pred_valid_q;

	// memory ports
	logic                 t_we;
	addr_t                t_waddr;
	logic [TW-1:0]        t_wdata;
	logic                 t_re;
	addr_t                t_raddr;
	logic [TW-1:0]        t_rdata;
	logic                 e_we;
	addr_t                e_waddr;
	logic [EW-1:0]        e_wdata;
	logic                 e_re;
	addr_t                e_raddr;
	logic [EW-1:0]        e_rdata;

	logic                 accept;
	logic                 slot_free;
	logic                 load_out;
	logic                 is_full;
	logic                 bad_read;
	logic signed [VW-1:0] probe_val;
	addr_t                probe_idx;
	logic                 go_right;
	cnt_t                 lo_n;
	cnt_t                 hi_n;
	cnt_t                 mid_n;
	cnt_t                 lo_inc;
	logic                 wr_go;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign is_full   = (count_q == cnt_t'(MAX_ITEMS));
	assign bad_read  = (CMPW'(index) >= CMPW'(count_q));

	// A finished request moves into the output register
	assign load_out  = slot_free &&
		((state_q == S_WRITE) || (state_q == S_RDATA) || (state_q == S_DONE));

	// Binary-search probe: compare the tail read last cycle, narrow the range
	assign probe_val = $signed(t_rdata[TW-1 -: VW]);
	assign probe_idx = t_rdata[IW-1:0];
	assign go_right  = probe_val < $signed(val_q);
	assign lo_n      = go_right ? cnt_t'(mid_q + cnt_t'(1)) : lo_q;
	assign hi_n      = go_right ? hi_q : mid_q;
	assign mid_n     = lo_n + ((hi_n - lo_n) >> 1);
	assign lo_inc    = lo_q + cnt_t'(1);

	// Tails memory: probes during search, tail rewrite at write-back
	assign t_re    = (state_q == S_IDLE) || (state_q == S_SEARCH);
	assign t_raddr = (state_q == S_IDLE) ? addr_t'(best_len_q >> 1) : addr_t'(mid_n);
	assign wr_go   = (state_q == S_WRITE) && slot_free;
	assign t_we    = wr_go;
	assign t_waddr = addr_t'(lo_q);
	assign t_wdata = {val_q, addr_t'(count_q)};

	// Element memory: value and predecessor per stored element
	assign e_re    = (state_q == S_IDLE);
	assign e_raddr = addr_t'(index);
	assign e_we    = wr_go;
	assign e_waddr = addr_t'(count_q);
	assign e_wdata = {val_q, pred_q, pred_ok_q};

	lis_ram #(
		.WIDTH (TW),
		.DEPTH (MAX_ITEMS)
	) u_tails_ram (
		.clk   (clk),
		.we    (t_we),
		.waddr (t_waddr),
		.wdata (t_wdata),
		.re    (t_re),
		.raddr (t_raddr),
		.rdata (t_rdata)
	);

	lis_ram #(
		.WIDTH (EW),
		.DEPTH (MAX_ITEMS)
	) u_elem_ram (
		.clk   (clk),
		.we    (e_we),
		.waddr (e_waddr),
		.wdata (e_wdata),
		.re    (e_re),
		.raddr (e_raddr),
		.rdata (e_rdata)
	);

	// Sequencer, sequence state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			st_q          <= lis_pkg::ST_OK;
			val_q         <= '0;
			count_q       <= '0;
			best_len_q    <= '0;
			best_tail_q   <= '0;
			lo_q          <= '0;
			hi_q          <= '0;
			mid_q         <= '0;
			pred_q        <= '0;
			pred_ok_q     <= 1'b0;
			out_valid_q   <= 1'b0;
			status_q      <= lis_pkg::ST_OK;
			position_q    <= '0;
			best_length_q <= '0;
			best_end_q    <= '0;
			entry_value_q <= '0;
			entry_pred_q  <= '0;
			pred_valid_q  <= 1'b0;
		end else begin
			// output slot fills on a finished request, empties when taken
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						val_q     <= value;
						lo_q      <= '0;
						hi_q      <= best_len_q;
						mid_q     <= best_len_q >> 1;
						pred_q    <= '0;
						pred_ok_q <= 1'b0;
						unique case (lis_pkg::action_t'(action))
							lis_pkg::ACT_PUSH: begin
								if (is_full) begin
									st_q    <= lis_pkg::ST_FULL;
									state_q <= S_DONE;
								end else if (best_len_q == '0) begin
									state_q <= S_WRITE;
								end else begin
									state_q <= S_SEARCH;
								end
							end
							lis_pkg::ACT_READ: begin
								if (bad_read) begin
									st_q    <= lis_pkg::ST_BAD_READ;
									state_q <= S_DONE;
								end else begin
									state_q <= S_RDATA;
								end
							end
							lis_pkg::ACT_CLEAR: begin
								count_q     <= '0;
								best_len_q  <= '0;
								best_tail_q <= '0;
								st_q        <= lis_pkg::ST_OK;
								state_q     <= S_DONE;
							end
							default: begin
								st_q    <= lis_pkg::ST_OK;
								state_q <= S_DONE;
							end
						endcase
					end
				end

				S_SEARCH: begin
					lo_q  <= lo_n;
					hi_q  <= hi_n;
					mid_q <= mid_n;
					if (go_right) begin
						pred_q    <= probe_idx;
						pred_ok_q <= 1'b1;
					end
					if (!(lo_n < hi_n)) begin
						state_q <= S_WRITE;
					end
				end

				S_WRITE: begin
					if (slot_free) begin
						count_q       <= count_q + cnt_t'(1);
						status_q      <= lis_pkg::ST_OK;
						position_q    <= lis_pkg::len_t'(lo_inc);
						entry_value_q <= '0;
						entry_pred_q  <= '0;
						pred_valid_q  <= 1'b0;
						if (lo_inc >= best_len_q) begin
							best_len_q    <= lo_inc;
							best_tail_q   <= addr_t'(count_q);
							best_length_q <= lis_pkg::len_t'(lo_inc);
							best_end_q    <= lis_pkg::idx_t'(addr_t'(count_q));
						end else begin
							best_length_q <= lis_pkg::len_t'(best_len_q);
							best_end_q    <= lis_pkg::idx_t'(best_tail_q);
						end
						state_q <= S_IDLE;
					end
				end

				S_RDATA: begin
					if (slot_free) begin
						status_q      <= lis_pkg::ST_OK;
						position_q    <= '0;
						best_length_q <= lis_pkg::len_t'(best_len_q);
						best_end_q    <= lis_pkg::idx_t'(best_tail_q);
						entry_value_q <= e_rdata[EW-1 -: VW];
						entry_pred_q  <= e_rdata[0] ? lis_pkg::idx_t'(e_rdata[IW:1]) : '0;
						pred_valid_q  <= e_rdata[0];
						state_q       <= S_IDLE;
					end
				end

				S_DONE: begin
					// clear, unused code, full store or read past the count
					if (slot_free) begin
						status_q      <= st_q;
						position_q    <= '0;
						best_length_q <= lis_pkg::len_t'(best_len_q);
						best_end_q    <= lis_pkg::idx_t'(best_tail_q);
						entry_value_q <= '0;
						entry_pred_q  <= '0;
						pred_valid_q  <= 1'b0;
						state_q       <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign position    = position_q;
	assign best_length = best_length_q;
	assign best_end    = best_end_q;
	assign entry_value = entry_value_q;
	assign entry_pred  = entry_pred_q;
	assign pred_valid  = pred_valid_q;

endmodule

// ----- rtl/core/lis_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module lis_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, registered read data, holds when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- dv/lis_scoreboard_pkg.sv -----
// Scoreboard for the LIS tracker: tails-table predictor and response checking.
`timescale 1ns / 1ps

package lis_scoreboard_pkg;
	import lis_pkg::*;

	localparam int unsigned STORE_DEPTH = 1024;

	typedef struct {
		status_t status;
		len_t    position;
		len_t    best_length;
		idx_t    best_end;
		val_t    entry_value;
		idx_t    entry_pred;
		logic    pred_valid;
	} lis_resp_t;

	class lis_scoreboard;
		// Mirror of the element store and tails table
		val_t        elem_vals[STORE_DEPTH];
		idx_t        elem_preds[STORE_DEPTH];
		bit          elem_has_pred[STORE_DEPTH];
		idx_t        tails[STORE_DEPTH];
		int unsigned elem_count;
		int unsigned best_len;
		idx_t        best_tail;

		lis_resp_t   expected_resps[$];
		int unsigned errors;

		function new();
			elem_count = 0;
			best_len   = 0;
			best_tail  = '0;
			errors     = 0;
		endfunction

		function int unsigned pending();
			return expected_resps.size();
		endfunction

		// Apply one accepted request and queue the response it must produce
		function void note_request(action_t act, val_t val, idx_t idx);
			lis_resp_t   r;
			int unsigned lo;
			int unsigned hi;
			int unsigned mid;
			r.status      = ST_OK;
			r.position    = '0;
			r.entry_value = '0;
			r.entry_pred  = '0;
			r.pred_valid  = 1'b0;
			case (act)
			ACT_PUSH: begin
				if (elem_count >= STORE_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					// first tail whose value is not below the pushed value
					lo = 0;
					hi = best_len;
					while (lo < hi) begin
						mid = lo + (hi - lo) / 2;
						if ($signed(elem_vals[tails[mid]]) < $signed(val))
							lo = mid + 1;
						else
							hi = mid;
					end
					elem_vals[elem_count]     = val;
					elem_has_pred[elem_count] = (lo > 0);
					elem_preds[elem_count]    = (lo > 0) ? tails[lo-1] : idx_t'(0);
					tails[lo] = idx_t'(elem_count);
					if (lo + 1 >= best_len) begin
						best_len  = lo + 1;
						best_tail = idx_t'(elem_count);
					end
					elem_count++;
					r.position = len_t'(lo + 1);
				end
			end
			ACT_READ: begin
				if (idx >= elem_count) begin
					r.status = ST_BAD_READ;
				end else begin
					r.entry_value = elem_vals[idx];
					if (elem_has_pred[idx]) begin
						r.entry_pred = elem_preds[idx];
						r.pred_valid = 1'b1;
					end
				end
			end
			ACT_CLEAR: begin
				elem_count = 0;
				best_len   = 0;
				best_tail  = '0;
			end
			default: ;
			endcase
			r.best_length = len_t'(best_len);
			r.best_end    = best_tail;
			expected_resps.push_back(r);
		endfunction

		function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
			if (exp_v !== act_v) begin
				errors++;
				$display("%0t: %s mismatch: expected %0h, actual %0h",
					$time, name, exp_v, act_v);
			end
		endfunction

		// Compare one accepted response against the oldest expectation
		function void check_response(lis_resp_t got);
			lis_resp_t exp_r;
			if (expected_resps.size() == 0) begin
				errors++;
				$display("%0t: response mismatch: expected none, actual status %0h",
					$time, got.status);
				return;
			end
			exp_r = expected_resps.pop_front();
			compare_field("status",      exp_r.status,      got.status);
			compare_field("position",    exp_r.position,    got.position);
			compare_field("best_length", exp_r.best_length, got.best_length);
			compare_field("best_end",    exp_r.best_end,    got.best_end);
			compare_field("entry_value", exp_r.entry_value, got.entry_value);
			compare_field("entry_pred",  exp_r.entry_pred,  got.entry_pred);
			compare_field("pred_valid",  exp_r.pred_valid,  got.pred_valid);
		endfunction
	endclass

endpackage

// ----- dv/longest_increasing_subsequence_tb.sv -----
// Testbench top for the longest increasing subsequence tracker.
`timescale 1ns / 1ps

module longest_increasing_subsequence_tb;
	import lis_pkg::*;
	import lis_scoreboard_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam int unsigned ITEM_TARGET = 1800;
	localparam int unsigned SHORT_PHASE = 420;

	// value shapes for pushes
	localparam int VM_WIDE   = 0;
	localparam int VM_NARROW = 1;
	localparam int VM_RAMP   = 2;
	localparam int VM_EDGE   = 3;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [1:0]        action;
	logic signed [31:0] value;
	logic [9:0]        index;
	logic              out_valid;
	logic              out_ready;
	logic [1:0]        status;
	logic [10:0]       position;
	logic [10:0]       best_length;
	logic [9:0]        best_end;
	logic signed [31:0] entry_value;
	logic [9:0]        entry_pred;
	logic              pred_valid;

	lis_scoreboard sb;
	int unsigned   items_sent = 0;
	int unsigned   resps_seen = 0;
	int unsigned   cycle_count = 0;
	bit            send_gaps_on = 1'b1;
	bit            recv_stalls_on = 1'b1;
	int            ramp_val = 0;
	bit            walking = 1'b0;
	idx_t          walk_idx = '0;

	longest_increasing_subsequence u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.value       (value),
		.index       (index),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.position    (position),
		.best_length (best_length),
		.best_end    (best_end),
		.entry_value (entry_value),
		.entry_pred  (entry_pred),
		.pred_valid  (pred_valid)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Run watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic val_t pick_value(int mode);
		case (mode)
		VM_WIDE:   return $urandom;
		VM_NARROW: return $urandom_range(0, 16) - 8;
		VM_RAMP: begin
			ramp_val += $urandom_range(0, 3);
			return ramp_val;
		end
		default: begin
			case ($urandom_range(0, 3))
			0:       return 32'h8000_0000;
			1:       return 32'h7fff_ffff;
			2:       return 32'h0000_0000;
			default: return 32'hffff_ffff;
			endcase
		end
		endcase
	endfunction

	// One request transaction: optional gap, then hold valid until accepted
	task automatic send_request(action_t act, val_t val, idx_t idx);
		int gap;
		gap = send_gaps_on ? $urandom_range(0, 11) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action   <= act;
		value    <= val;
		index    <= idx;
		do @(posedge clk); while (!in_ready);
		sb.note_request(act, val, idx);
		if (act == ACT_CLEAR) begin
			walking  = 1'b0;
			ramp_val = $urandom_range(0, 1000) - 500;
		end
		items_sent++;
		if (items_sent % 50 == 0)
			send_gaps_on = ($urandom_range(0, 3) != 0);
	endtask

	// Hold off new requests until every response is back
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	// Walk the best chain backwards, one element per read
	task automatic read_chain();
		if (!walking) begin
			walk_idx = sb.best_tail;
			walking  = 1'b1;
		end
		send_request(ACT_READ, $urandom, walk_idx);
		if (sb.elem_has_pred[walk_idx])
			walk_idx = sb.elem_preds[walk_idx];
		else
			walking = 1'b0;
	endtask

	task automatic read_any();
		if (sb.elem_count == 0)
			send_request(ACT_READ, $urandom, idx_t'($urandom));
		else if ($urandom_range(0, 1) == 0)
			read_chain();
		else
			send_request(ACT_READ, $urandom, idx_t'($urandom_range(0, sb.elem_count - 1)));
	endtask

	task automatic read_beyond();
		if (sb.elem_count >= STORE_DEPTH)
			read_any();
		else
			send_request(ACT_READ, $urandom,
				idx_t'($urandom_range(sb.elem_count, STORE_DEPTH - 1)));
	endtask

	// Edge values, equal values, empty and out-of-range reads, unused action
	task automatic run_directed();
		send_request(ACT_READ,  32'h0, 10'd0);
		send_request(ACT_PUSH,  32'h0, 10'd0);
		send_request(ACT_PUSH,  32'h8000_0000, 10'd0);
		send_request(ACT_PUSH,  32'h7fff_ffff, 10'd0);
		send_request(ACT_PUSH,  32'h7fff_ffff, 10'd0);
		send_request(ACT_PUSH,  32'hffff_ffff, 10'd0);
		send_request(ACT_PUSH,  32'hffff_ffff, 10'd0);
		send_request(ACT_PUSH,  32'h0000_0005, 10'h3ff);
		send_request(ACT_READ,  32'h0, 10'd0);
		send_request(ACT_READ,  32'h0, 10'd6);
		send_request(ACT_READ,  32'h0, 10'd5);
		send_request(ACT_READ,  32'h0, 10'd7);
		send_request(ACT_READ,  32'hffff_ffff, 10'h3ff);
		send_request(ACT_NONE,  32'hdead_beef, 10'h2aa);
		send_request(ACT_CLEAR, 32'h1234_5678, 10'h155);
		send_request(ACT_READ,  32'h0, 10'd0);
		send_request(ACT_PUSH,  32'h5555_5555, 10'd0);
		send_request(ACT_PUSH,  32'haaaa_aaaa, 10'd0);
		send_request(ACT_PUSH,  32'h5555_5556, 10'd0);
		send_request(ACT_PUSH,  32'h5555_5555, 10'd0);
		send_request(ACT_READ,  32'h0, 10'd2);
		send_request(ACT_READ,  32'h0, 10'd3);
		send_request(ACT_NONE,  32'h0, 10'd0);
	endtask

	// Mostly a fresh sequence of pushes, mixed with reads and some noise
	task automatic run_sequence(int steps);
		int vmode;
		int r;
		if ($urandom_range(0, 9) != 0)
			send_request(ACT_CLEAR, $urandom, idx_t'($urandom));
		vmode = $urandom_range(VM_WIDE, VM_EDGE);
		repeat (steps) begin
			r = $urandom_range(0, 99);
			if (r < 70)
				send_request(ACT_PUSH,
					pick_value(($urandom_range(0, 4) == 0) ? VM_WIDE : vmode),
					idx_t'($urandom));
			else if (r < 85)
				read_any();
			else if (r < 92)
				read_beyond();
			else if (r < 97)
				send_request(ACT_NONE, $urandom, idx_t'($urandom));
			else
				send_request(ACT_CLEAR, $urandom, idx_t'($urandom));
		end
	endtask

	// Fill the store past capacity with a long rising run, then read it back
	task automatic run_full_store();
		send_request(ACT_CLEAR, $urandom, idx_t'($urandom));
		repeat (STORE_DEPTH + 6) begin
			if ($urandom_range(0, 19) == 0)
				read_any();
			send_request(ACT_PUSH,
				pick_value(($urandom_range(0, 9) == 0) ? VM_WIDE : VM_RAMP),
				idx_t'($urandom));
		end
		repeat (30)
			send_request(ACT_READ, $urandom, idx_t'($urandom_range(0, STORE_DEPTH - 1)));
		repeat (25)
			read_chain();
		send_request(ACT_PUSH, 32'h8000_0000, 10'd0);
		send_request(ACT_NONE, $urandom, idx_t'($urandom));
	endtask

	// Response side: random stalls, check every accepted transaction
	initial begin
		lis_resp_t got;
		int        stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			stall = recv_stalls_on ? $urandom_range(0, 11) : 0;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			got.status      = status;
			got.position    = position;
			got.best_length = best_length;
			got.best_end    = best_end;
			got.entry_value = entry_value;
			got.entry_pred  = entry_pred;
			got.pred_valid  = pred_valid;
			sb.check_response(got);
			resps_seen++;
			if (resps_seen % 40 == 0)
				recv_stalls_on = ($urandom_range(0, 3) != 0);
		end
	end

	// Stimulus and end of run
	initial begin
		sb       = new();
		in_valid = 1'b0;
		action   = ACT_NONE;
		value    = '0;
		index    = '0;
		arst_n   = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		while (items_sent < SHORT_PHASE)
			run_sequence($urandom_range(1, 40));
		drain();
		run_full_store();
		while (items_sent < ITEM_TARGET)
			run_sequence($urandom_range(1, 40));

		drain();
		repeat (30) @(posedge clk);
		if (sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
